// File: rtl/core/atd_pkg.sv
// ----------------------------------------------------------------------------
// atd_pkg
// Shared widths, codes and types of the activity transition debouncer.
// ----------------------------------------------------------------------------
package atd_pkg;

    localparam int ACT_W  = 4;
    localparam int CONF_W = 3;
    localparam int TS_W   = 48;
    localparam int DEB_W  = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [ACT_W-1:0] ACT_UNKNOWN = '0;

    typedef enum logic {
        KIND_STOPPED = 1'b0,
        KIND_STARTED = 1'b1
    } t_kind;

    typedef struct packed {
        logic [ACT_W-1:0]  activity;
        logic [CONF_W-1:0] confidence;
        logic [TS_W-1:0]   timestamp_us;
        logic              sample_valid;
        logic              is_activity_sensor;
        logic              restart;
        logic              mock_flag;
        logic              replay_flag;
    } t_sample;

    typedef struct packed {
        t_kind             kind;
        logic [ACT_W-1:0]  activity;
        logic [CONF_W-1:0] confidence;
        logic [TS_W-1:0]   time_us;
        logic              mock;
        logic              replay;
        logic              last;
    } t_event;

    typedef struct packed {
        logic [1:0] n;
        t_event     ev0;
        t_event     ev1;
    } t_push;

endpackage

// File: rtl/core/atd_in_if.sv
// ----------------------------------------------------------------------------
// atd_in_if
// Sample channel: valid/ready handshake with one activity sample.
// ----------------------------------------------------------------------------
interface atd_in_if;
    logic                        valid;
    logic                        ready;
    logic [atd_pkg::ACT_W-1:0]   activity;
    logic [atd_pkg::CONF_W-1:0]  confidence;
    logic [atd_pkg::TS_W-1:0]    timestamp_us;
    logic                        sample_valid;
    logic                        is_activity_sensor;
    logic                        restart;
    logic                        mock_flag;
    logic                        replay_flag;

    modport source (
        output valid, activity, confidence, timestamp_us, sample_valid,
               is_activity_sensor, restart, mock_flag, replay_flag,
        input  ready
    );

    modport sink (
        input  valid, activity, confidence, timestamp_us, sample_valid,
               is_activity_sensor, restart, mock_flag, replay_flag,
        output ready
    );
endinterface

// File: rtl/core/atd_out_if.sv
// ----------------------------------------------------------------------------
// atd_out_if
// Event channel: valid/ready handshake with one stopped/started event.
// ----------------------------------------------------------------------------
interface atd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        event_kind;
    logic [atd_pkg::ACT_W-1:0]   event_activity;
    logic [atd_pkg::CONF_W-1:0]  event_confidence;
    logic [atd_pkg::TS_W-1:0]    event_time_us;
    logic                        out_mock;
    logic                        out_replay;
    logic                        last_event;

    modport source (
        output valid, event_kind, event_activity, event_confidence, event_time_us,
               out_mock, out_replay, last_event,
        input  ready
    );

    modport sink (
        input  valid, event_kind, event_activity, event_confidence, event_time_us,
               out_mock, out_replay, last_event,
        output ready
    );
endinterface

// File: rtl/core/atd_cfg_if.sv
// ----------------------------------------------------------------------------
// atd_cfg_if
// Configuration write channel for the debounce time register.
// ----------------------------------------------------------------------------
interface atd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [atd_pkg::DEB_W-1:0]   data;

    modport source (
        output valid, data,
        input  ready
    );

    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// File: rtl/core/atd_in_stage.sv
// ----------------------------------------------------------------------------
// atd_in_stage
// Input register: captures one sample transaction per cycle while its held sample is taken.
// ----------------------------------------------------------------------------
module atd_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    atd_in_if.sink           i_in,
    input  logic             i_take,
    output logic             o_valid,
    output atd_pkg::t_sample o_smp
);
    import atd_pkg::*;

    logic    r_valid;
    t_sample r_smp;
    logic    load;

    assign i_in.ready = i_rst_n && (!r_valid || i_take);
    assign load       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_smp.activity           <= i_in.activity;
            r_smp.confidence         <= i_in.confidence;
            r_smp.timestamp_us       <= i_in.timestamp_us;
            r_smp.sample_valid       <= i_in.sample_valid;
            r_smp.is_activity_sensor <= i_in.is_activity_sensor;
            r_smp.restart            <= i_in.restart;
            r_smp.mock_flag          <= i_in.mock_flag;
            r_smp.replay_flag        <= i_in.replay_flag;
        end
    end

    assign o_valid = r_valid;
    assign o_smp   = r_smp;

endmodule

// File: rtl/core/atd_decide.sv
// ----------------------------------------------------------------------------
// atd_decide
// Debounce state and transition decision for the registered sample.
// ----------------------------------------------------------------------------
module atd_decide #(
    parameter int TIME_BITS = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [atd_pkg::DEB_W-1:0]   i_cfg_data,
    input  logic                        i_smp_valid,
    input  atd_pkg::t_sample            i_smp,
    input  logic [atd_pkg::CNT_W-1:0]   i_free,
    output logic                        o_take,
    output atd_pkg::t_push              o_push
);
    import atd_pkg::*;

    logic [DEB_W-1:0]     r_debounce;
    logic [ACT_W-1:0]     r_held_act,    n_held_act;
    logic [CONF_W-1:0]    r_held_conf,   n_held_conf;
    logic                 r_have_held,   n_have_held;
    logic [TIME_BITS-1:0] r_last_seen,   n_last_seen;
    logic [TIME_BITS-1:0] r_last_change, n_last_change;
    logic                 r_have_change, n_have_change;

    logic [TIME_BITS-1:0] ts;
    logic [TIME_BITS-1:0] gap;
    logic                 hit;
    logic                 stale;
    logic                 same;
    logic                 bounced;
    logic                 change;
    logic                 has_stop;
    logic                 has_start;
    logic [1:0]           need;
    t_event               ev_stop;
    t_event               ev_start;

    assign ts        = TIME_BITS'(i_smp.timestamp_us);
    assign gap       = ts - r_last_change;
    assign hit       = i_smp.sample_valid && i_smp.is_activity_sensor;
    assign stale     = r_have_held && (ts <= r_last_seen);
    assign same      = i_smp.activity == r_held_act;
    assign bounced   = r_have_change && (gap < TIME_BITS'(r_debounce));
    assign has_stop  = r_held_act != ACT_UNKNOWN;
    assign has_start = i_smp.activity != ACT_UNKNOWN;
    assign change    = hit && !i_smp.restart && !stale && r_have_held && !same && !bounced;
    assign need      = change ? (2'(has_stop) + 2'(has_start)) : 2'd0;
    assign o_take    = i_smp_valid && (CNT_W'(need) <= i_free);

    always_comb begin
        ev_stop.kind       = KIND_STOPPED;
        ev_stop.activity   = r_held_act;
        ev_stop.confidence = r_held_conf;
        ev_stop.time_us    = TS_W'(ts);
        ev_stop.mock       = i_smp.mock_flag;
        ev_stop.replay     = i_smp.replay_flag;
        ev_stop.last       = !has_start;

        ev_start.kind       = KIND_STARTED;
        ev_start.activity   = i_smp.activity;
        ev_start.confidence = i_smp.confidence;
        ev_start.time_us    = TS_W'(ts);
        ev_start.mock       = i_smp.mock_flag;
        ev_start.replay     = i_smp.replay_flag;
        ev_start.last       = 1'b1;

        o_push.n   = o_take ? need : 2'd0;
        o_push.ev0 = has_stop ? ev_stop : ev_start;
        o_push.ev1 = ev_start;
    end

    always_comb begin
        n_held_act    = r_held_act;
        n_held_conf   = r_held_conf;
        n_have_held   = r_have_held;
        n_last_seen   = r_last_seen;
        n_last_change = r_last_change;
        n_have_change = r_have_change;
        if (o_take && hit) begin
            if (i_smp.restart) begin
                n_held_act    = i_smp.activity;
                n_held_conf   = i_smp.confidence;
                n_have_held   = 1'b1;
                n_last_seen   = ts;
                n_last_change = '0;
                n_have_change = 1'b0;
            end else if (!stale) begin
                n_last_seen = ts;
                if (!r_have_held) begin
                    n_held_act  = i_smp.activity;
                    n_held_conf = i_smp.confidence;
                    n_have_held = 1'b1;
                end else if (same) begin
                    n_held_conf = i_smp.confidence;
                end else if (!bounced) begin
                    n_held_act    = i_smp.activity;
                    n_held_conf   = i_smp.confidence;
                    n_last_change = ts;
                    n_have_change = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= '0;
        end else if (i_cfg_we) begin
            r_debounce <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_held_act    <= ACT_UNKNOWN;
            r_held_conf   <= '0;
            r_have_held   <= 1'b0;
            r_last_seen   <= '0;
            r_last_change <= '0;
            r_have_change <= 1'b0;
        end else begin
            r_held_act    <= n_held_act;
            r_held_conf   <= n_held_conf;
            r_have_held   <= n_have_held;
            r_last_seen   <= n_last_seen;
            r_last_change <= n_last_change;
            r_have_change <= n_have_change;
        end
    end

`ifndef SYNTHESIS
    a_change_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && change && !i_cfg_we) |=> (r_have_change && r_last_change == $past(ts)))
        else $error("transition not recorded in debounce state");

    a_first_event_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n != 2'd0) |-> (o_push.ev0.activity != ACT_UNKNOWN))
        else $error("event emitted for unknown activity");
`endif

endmodule

// File: rtl/core/atd_evt_fifo.sv
// ----------------------------------------------------------------------------
// atd_evt_fifo
// Result queue: takes up to two events per cycle, drives one per transaction.
// ----------------------------------------------------------------------------
module atd_evt_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  atd_pkg::t_push              i_push,
    output logic [atd_pkg::CNT_W-1:0]   o_free,
    atd_out_if.source                   o_out
);
    import atd_pkg::*;

    t_event           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr,    n_wr;
    logic [PTR_W-1:0] r_rd,    n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;
    t_event           head;

    assign pop  = o_out.valid && o_out.ready;
    assign head = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.n);
        n_rd    = r_rd + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push.n) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.ev0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[PTR_W'(r_wr + 1'b1)] <= i_push.ev1;
        end
    end

    assign o_free                 = CNT_W'(FIFO_DEPTH) - r_count;
    assign o_out.valid            = r_count != '0;
    assign o_out.event_kind       = head.kind;
    assign o_out.event_activity   = head.activity;
    assign o_out.event_confidence = head.confidence;
    assign o_out.event_time_us    = head.time_us;
    assign o_out.out_mock         = head.mock;
    assign o_out.out_replay       = head.replay;
    assign o_out.last_event       = head.last;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + CNT_W'(i_push.n)) <= CNT_W'(FIFO_DEPTH))
        else $error("event queue overflow");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n == 2'd0 && pop) |=> (r_count == $past(r_count) - 1'b1))
        else $error("event queue count out of step");
`endif

endmodule

// File: rtl/core/activity_transition_debouncer_core.sv
// ----------------------------------------------------------------------------
// activity_transition_debouncer_core
// Turns timestamped activity samples into stopped/started events.
//
// i_in carries one activity sample per transaction; o_out carries one event
// per transaction, last_event marking the final event of a sample; i_cfg
// writes debounce_us (ready whenever out of reset) and clears the tracking state.
// A sample goes into the input register at its transaction and is decided from
// that register once the event queue has room for its events; its events are then
// written into the queue, whose head drives o_out.
// A sample is taken every cycle while the four-entry event queue has room for
// its events; a sample that yields two events needs two output transactions, so
// such samples are held to the rate of the event port.
// When o_out stalls the queue fills and i_in.ready drops once the next
// sample's events no longer fit; nothing is lost.
// Reset (synchronous, active low) empties the pipeline and the queue, clears
// the tracking state and sets debounce_us to zero.
// ----------------------------------------------------------------------------
module activity_transition_debouncer_core #(
    parameter int TIME_BITS = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    atd_in_if.sink    i_in,
    atd_cfg_if.sink   i_cfg,
    atd_out_if.source o_out
);
    import atd_pkg::*;

    logic             smp_valid;
    t_sample          smp;
    logic             take;
    logic [CNT_W-1:0] free;
    t_push            push;
    logic             cfg_we;

    assign i_cfg.ready = i_rst_n;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    atd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (smp_valid),
        .o_smp   (smp)
    );

    atd_decide #(
        .TIME_BITS (TIME_BITS)
    ) u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg.data),
        .i_smp_valid (smp_valid),
        .i_smp       (smp),
        .i_free      (free),
        .o_take      (take),
        .o_push      (push)
    );

    atd_evt_fifo u_evt_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (free),
        .o_out   (o_out)
    );

endmodule
